// ===== hw/rtl/running_image_mean_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RUNNING_IMAGE_MEAN_DEFINES_SVH
`define RUNNING_IMAGE_MEAN_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RIM_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RIM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rim_pkg.sv =====
// ----------------------------------------------------------------------------
// rim_pkg
// Shared constants and the word carried down the divider chain.
// ----------------------------------------------------------------------------
package rim_pkg;

  localparam int MAX_PIXELS = 131072;
  localparam int POS_W      = $clog2(MAX_PIXELS);
  localparam int SIZE_W     = 18;
  localparam int PIX_W      = 16;
  localparam int NUM_CELLS  = PIX_W;
  localparam int PADDR_W    = 3;

  localparam logic [PADDR_W-1:0] ADDR_IMAGE_PIXELS = 3'd0;
  localparam logic [SIZE_W-1:0]  IMAGE_PIXELS_RST  = SIZE_W'(MAX_PIXELS);

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] m;
    logic             neg;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] rem;
    logic [PIX_W-1:0] q;
    logic [PIX_W-1:0] n;
    logic             restart;
    logic [POS_W-1:0] pos;
    logic             last;
  } cell_t;

endpackage

// ===== hw/rtl/rim_ram.sv =====
// ----------------------------------------------------------------------------
// rim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rim_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/rim_div_cell.sv =====
// ----------------------------------------------------------------------------
// rim_div_cell
// One restoring-division step: retires one quotient bit per cell.
// ----------------------------------------------------------------------------
module rim_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  rim_pkg::cell_t d_in,
  output rim_pkg::cell_t d_out
);

  logic [rim_pkg::PIX_W:0]   cat;
  logic                      ge;
  logic [rim_pkg::PIX_W:0]   diff;
  rim_pkg::cell_t            d_next;

  always_comb begin
    cat    = {d_in.rem, d_in.a[rim_pkg::PIX_W-1]};
    ge     = cat >= {1'b0, d_in.n};
    diff   = cat - {1'b0, d_in.n};
    d_next = d_in;
    d_next.rem = ge ? diff[rim_pkg::PIX_W-1:0] : cat[rim_pkg::PIX_W-1:0];
    d_next.q   = {d_in.q[rim_pkg::PIX_W-2:0], ge};
    d_next.a   = {d_in.a[rim_pkg::PIX_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (adv) begin
      d_out <= d_next;
    end
  end

endmodule

// ===== hw/rtl/running_image_mean.sv =====
// ----------------------------------------------------------------------------
// running_image_mean
// Per-pixel running mean over a stream of images.
// ----------------------------------------------------------------------------
// Pixels enter on the pixel channel (pixel_valid/pixel_ready), one word per
// pixel in raster order, image after image. Each word yields one word on the
// mean channel (mean_valid/mean_ready) carrying the updated mean and a flag
// on the last pixel of an image. image_pixels is set over the APB port at
// byte address 0; the user must set it only while the stream is idle, as
// the block does not enforce it. Each word passes a mean store read, 16
// divider cells retiring one quotient bit each, and rounding into the
// output register. Throughput is one pixel per cycle while nothing stalls.
// When an image has 17 or fewer pixels, a pixel whose mean entry is still
// being updated in the chain waits until that write lands, so such small
// images run slower. When a mean word waits with mean_ready low, the whole
// chain holds and pixel_ready drops with it. Reset clears the image count,
// series, position and the chain; image_pixels returns to 131072. Mean
// entries are not cleared: the first image after reset overwrites them.
// ----------------------------------------------------------------------------
module running_image_mean (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rim_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [rim_pkg::PIX_W-1:0]     pixel_value,
  input  logic [rim_pkg::PIX_W-1:0]     series_number,
  output logic                          mean_valid,
  input  logic                          mean_ready,
  output logic [rim_pkg::PIX_W-1:0]     mean_value,
  output logic                          image_last
);

  localparam int W = rim_pkg::PIX_W;
  localparam int P = rim_pkg::POS_W;

  logic [rim_pkg::SIZE_W-1:0] image_pixels;
  logic [W-1:0]               image_count;
  logic [W-1:0]               stored_series;
  logic [P-1:0]               pixel_position;
  logic                       restart_image;

  logic                       adv;
  logic                       hazard;
  logic                       accept;
  logic [rim_pkg::SIZE_W-1:0] size_eff;
  logic [P-1:0]               size_m1;
  logic                       first_px;
  logic                       restart_now;
  logic [W-1:0]               count_inc;
  logic [W-1:0]               n_now;
  logic                       last_now;

  // stage 0: waiting on the mean store read
  logic         s0_valid;
  logic [W-1:0] s0_x;
  logic [W-1:0] s0_n;
  logic         s0_restart;
  logic [P-1:0] s0_pos;
  logic         s0_last;
  logic [W-1:0] rd_mean;
  logic [W:0]   diff;

  rim_pkg::cell_t chain [rim_pkg::NUM_CELLS+1];
  logic [rim_pkg::NUM_CELLS:0] hit;

  // final rounding
  rim_pkg::cell_t c;
  logic [W:0]     r2;
  logic           round_up;
  logic [W:0]     q_round;
  logic [W+1:0]   nm;
  logic [W-1:0]   result;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == rim_pkg::ADDR_IMAGE_PIXELS) begin
      prdata = 32'(image_pixels);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_pixels <= rim_pkg::IMAGE_PIXELS_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr == rim_pkg::ADDR_IMAGE_PIXELS) begin
      image_pixels <= pwdata[rim_pkg::SIZE_W-1:0];
    end
  end

  // ---------------- input stage ----------------
  always_comb begin
    if (image_pixels == '0) begin
      size_eff = rim_pkg::SIZE_W'(1);
    end else if (image_pixels > rim_pkg::IMAGE_PIXELS_RST) begin
      size_eff = rim_pkg::IMAGE_PIXELS_RST;
    end else begin
      size_eff = image_pixels;
    end
  end
  assign size_m1 = P'(size_eff - rim_pkg::SIZE_W'(1));

  assign first_px    = pixel_position == '0;
  assign restart_now = first_px ? (image_count == '0 || series_number != stored_series)
                                : restart_image;
  assign count_inc   = (image_count == '1) ? image_count : image_count + W'(1);
  assign n_now       = first_px ? count_inc : image_count;
  assign last_now    = pixel_position >= size_m1;

  assign adv = !mean_valid || mean_ready;

  // pixel whose entry is still in flight must wait for its write
  assign hit[0] = s0_valid && s0_pos == pixel_position;
  for (genvar k = 1; k <= rim_pkg::NUM_CELLS; k++) begin : g_hit
    assign hit[k] = chain[k].valid && chain[k].pos == pixel_position;
  end
  assign hazard      = |hit;
  assign pixel_ready = adv && !hazard;
  assign accept      = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_count    <= '0;
      stored_series  <= '0;
      pixel_position <= '0;
      restart_image  <= 1'b0;
      s0_valid       <= 1'b0;
    end else begin
      if (accept) begin
        if (first_px) begin
          image_count   <= count_inc;
          restart_image <= restart_now;
          if (restart_now) begin
            stored_series <= series_number;
          end
        end
        pixel_position <= last_now ? '0 : pixel_position + P'(1);
      end
      if (adv) begin
        s0_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x       <= pixel_value;
      s0_n       <= n_now;
      s0_restart <= restart_now;
      s0_pos     <= pixel_position;
      s0_last    <= last_now;
    end
  end

  rim_ram #(
    .WIDTH (W),
    .DEPTH (rim_pkg::MAX_PIXELS)
  ) u_mean_store (
    .clk   (clk),
    .we    (adv && c.valid),
    .waddr (c.pos),
    .wdata (result),
    .re    (adv),
    .raddr (pixel_position),
    .rdata (rd_mean)
  );

  // ---------------- divider chain ----------------
  always_comb begin
    diff = {1'b0, s0_x} - {1'b0, rd_mean};
    chain[0].valid   = s0_valid;
    chain[0].x       = s0_x;
    chain[0].m       = rd_mean;
    chain[0].neg     = diff[W];
    chain[0].a       = diff[W] ? W'(-diff) : diff[W-1:0];
    chain[0].rem     = '0;
    chain[0].q       = '0;
    chain[0].n       = s0_n;
    chain[0].restart = s0_restart;
    chain[0].pos     = s0_pos;
    chain[0].last    = s0_last;
  end

  for (genvar k = 0; k < rim_pkg::NUM_CELLS; k++) begin : g_cell
    rim_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .d_in  (chain[k]),
      .d_out (chain[k+1])
    );
  end

  // ---------------- round, clamp, output ----------------
  always_comb begin
    c        = chain[rim_pkg::NUM_CELLS];
    r2       = {c.rem, 1'b0};
    // nearest, ties to even
    round_up = (r2 > {1'b0, c.n}) || (r2 == {1'b0, c.n} && c.q[0]);
    q_round  = {1'b0, c.q} + (W+1)'(round_up);
    nm       = c.neg ? ({2'b00, c.m} - {1'b0, q_round})
                     : ({2'b00, c.m} + {1'b0, q_round});
    if (c.restart) begin
      result = c.x;
    end else if (nm[W+1]) begin
      result = '0;
    end else if (nm[W]) begin
      result = '1;
    end else begin
      result = nm[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (adv) begin
      mean_valid <= c.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mean_value <= result;
      image_last <= c.last;
    end
  end

endmodule

// ===== hw/rtl/rim_checker.sv =====
// ----------------------------------------------------------------------------
// rim_checker
// Port-level checks on the running mean block, bound to the top level.
// ----------------------------------------------------------------------------
`include "running_image_mean_defines.svh"

module rim_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pixel_valid,
  input logic                      pixel_ready,
  input logic                      mean_valid,
  input logic                      mean_ready,
  input logic [rim_pkg::PIX_W-1:0] mean_value,
  input logic                      image_last
);

  // words accepted but not yet delivered: input stage, cells, output reg
  localparam int MAX_FLIGHT = rim_pkg::NUM_CELLS + 2;

  logic [4:0] flight;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = pixel_valid && pixel_ready;
  assign out_acc = mean_valid && mean_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      flight <= '0;
    end else begin
      flight <= flight + 5'(in_acc) - 5'(out_acc);
    end
  end

  `RIM_ASSERT_NOW(a_flight_bound, clk, rst, 1'b1, flight <= 5'(MAX_FLIGHT), "too many words in flight")
  `RIM_ASSERT_NOW(a_no_phantom, clk, rst, mean_valid, flight != 5'd0, "mean word with no pixel")
  `RIM_ASSERT_NEXT(a_out_hold, clk, rst, mean_valid && !mean_ready, mean_valid && $stable(mean_value) && $stable(image_last), "stalled mean word changed")

endmodule

bind running_image_mean rim_checker u_rim_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_valid (pixel_valid),
  .pixel_ready (pixel_ready),
  .mean_valid  (mean_valid),
  .mean_ready  (mean_ready),
  .mean_value  (mean_value),
  .image_last  (image_last)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for running_image_mean: directed images, then random
// phases of pixels with size changes in between, bursty input, stalled output.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 500;

  typedef struct {
    logic [rim_pkg::PIX_W-1:0] mean;
    logic                      last;
  } mean_word_t;

  class mean_scoreboard;
    logic [rim_pkg::PIX_W-1:0] mean_mem [rim_pkg::MAX_PIXELS];
    int unsigned      img_count;
    logic [rim_pkg::PIX_W-1:0] cur_series;
    int unsigned      pos;
    bit               restart;
    int unsigned      size_reg;
    int unsigned      covered;
    int unsigned      errors;
    int unsigned      checked;
    mean_word_t       pending[$];

    function new();
      img_count = 0;
      cur_series = '0;
      pos = 0;
      restart = 0;
      size_reg = rim_pkg::MAX_PIXELS;
      covered = 0;
      errors = 0;
      checked = 0;
    endfunction

    function int unsigned eff_size(int unsigned raw);
      if (raw == 0) return 1;
      if (raw > rim_pkg::MAX_PIXELS) return rim_pkg::MAX_PIXELS;
      return raw;
    endfunction

    function int round_div(int d, int unsigned n);
      int unsigned a, q, r;
      a = (d < 0) ? -d : d;
      q = a / n;
      r = a % n;
      if (2 * r > n || (2 * r == n && q[0])) q++;
      return (d < 0) ? -int'(q) : int'(q);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch @%0t: %s", $time, what);
    endtask

    function void note_pixel(logic [rim_pkg::PIX_W-1:0] x, logic [rim_pkg::PIX_W-1:0] s);
      int unsigned size;
      int m, nm;
      mean_word_t w;
      size = eff_size(size_reg);
      if (pos == 0) begin
        restart = (img_count == 0) || (s != cur_series);
        if (restart) cur_series = s;
        if (img_count < 65535) img_count++;
      end
      if (restart) begin
        nm = int'(x);
      end else begin
        m = int'(mean_mem[pos]);
        nm = m + round_div(int'(x) - m, img_count);
        if (nm < 0) nm = 0;
        if (nm > 65535) nm = 65535;
      end
      mean_mem[pos] = nm[rim_pkg::PIX_W-1:0];
      if (pos + 1 > covered) covered = pos + 1;
      w.mean = nm[rim_pkg::PIX_W-1:0];
      w.last = (pos >= size - 1);
      pos = w.last ? 0 : pos + 1;
      pending.push_back(w);
    endfunction

    task check_mean(logic [rim_pkg::PIX_W-1:0] m, logic l);
      mean_word_t w;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word mean=%0d last=%0b", m, l));
      end else begin
        w = pending.pop_front();
        if (m !== w.mean) report($sformatf("mean_value %0d, want %0d", m, w.mean));
        if (l !== w.last) report($sformatf("image_last %0b, want %0b", l, w.last));
      end
    endtask
  endclass

  logic              clk = 0;
  logic              rst = 1;
  logic              psel = 0, penable = 0, pwrite = 0;
  logic [rim_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              pixel_valid = 0;
  logic              pixel_ready;
  logic [rim_pkg::PIX_W-1:0] pixel_value = '0;
  logic [rim_pkg::PIX_W-1:0] series_number = '0;
  logic              mean_valid;
  logic              mean_ready = 0;
  logic [rim_pkg::PIX_W-1:0] mean_value;
  logic              image_last;

  mean_scoreboard sb = new();
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned cyc = 0;
  int unsigned size_writes = 0;

  running_image_mean dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // receiver: stall pattern changes whenever the low six bits of cyc are zero
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc[5:0] == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: mean_ready <= 1'b1;
      1: mean_ready <= $urandom_range(0, 1);
      2: mean_ready <= ($urandom_range(0, 7) == 0);
      default: mean_ready <= ~cyc[2];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && mean_valid && mean_ready) sb.check_mean(mean_value, image_last);
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (mean_valid && mean_ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress, %0d words still expected", sb.pending.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task apb_write_size(int unsigned v);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= rim_pkg::ADDR_IMAGE_PIXELS;
    pwdata <= {14'($urandom), v[rim_pkg::SIZE_W-1:0]};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.size_reg = v[rim_pkg::SIZE_W-1:0];
    size_writes++;
  endtask

  task send_pixel(logic [rim_pkg::PIX_W-1:0] x, logic [rim_pkg::PIX_W-1:0] s);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        pixel_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    pixel_valid <= 1;
    pixel_value <= x;
    series_number <= s;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    sb.note_pixel(x, s);
    sent++;
  endtask

  // drop valid right after the last accepted word, then wait for the means
  task drain;
    pixel_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [rim_pkg::PIX_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  // series for the next word; forces a restart when the image would
  // read mean entries that were never written
  function logic [rim_pkg::PIX_W-1:0] pick_series();
    if (sb.pos != 0) return 16'($urandom);
    if (sb.eff_size(sb.size_reg) > sb.covered)
      return sb.cur_series ^ 16'($urandom_range(1, 65535));
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return sb.cur_series;
  endfunction

  function int unsigned pick_size();
    int unsigned v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 1;
      2: v = rim_pkg::MAX_PIXELS;
      3: v = $urandom_range(rim_pkg::MAX_PIXELS + 1, 262143);
      4: v = $urandom_range(18, 64);
      default: v = $urandom_range(2, 17);
    endcase
    // mid image growth is only safe on a restart image
    if (sb.pos != 0 && !sb.restart && sb.eff_size(v) > sb.covered) v = sb.covered;
    return v;
  endfunction

  initial begin
    int unsigned n;
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: extremes, ties, series change, size zero/oversize/shrink
    apb_write_size(3);
    send_pixel(16'd0, 16'd5);  send_pixel(16'hFFFF, 16'd0); send_pixel(16'd1, 16'hFFFF);
    send_pixel(16'd1, 16'd5);  send_pixel(16'd0, 16'd1);    send_pixel(16'd4, 16'd2);
    send_pixel(16'hFFFF, 16'd5); send_pixel(16'hFFFF, 16'd5); send_pixel(16'd0, 16'd5);
    send_pixel(16'd7, 16'hFFFF); send_pixel(16'd9, 16'd0);  send_pixel(16'd3, 16'd0);
    drain();
    apb_write_size(0);
    send_pixel(16'd100, 16'hFFFF); send_pixel(16'd101, 16'hFFFF);
    drain();
    apb_write_size(262143);
    send_pixel(16'd10, 16'd9); send_pixel(16'd20, 16'd9); send_pixel(16'd30, 16'd9);
    send_pixel(16'd40, 16'd9); send_pixel(16'd50, 16'd9);
    drain();
    apb_write_size(2);   // position already past the new end
    send_pixel(16'd60, 16'd0); send_pixel(16'd70, 16'd9); send_pixel(16'd80, 16'd9);
    drain();

    while (sent < RANDOM_ITEMS + 25) begin
      apb_write_size(pick_size());
      n = $urandom_range(5, 60);
      repeat (n) send_pixel(pick_value(), pick_series());
      drain();
    end
    apb_write_size(rim_pkg::MAX_PIXELS);

    $display("%0d pixels sent, %0d means checked, %0d size writes, %0d images counted",
             sent, sb.checked, size_writes, sb.img_count);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d words missing", sb.errors, sb.pending.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/rim_pkg.sv
hw/rtl/rim_ram.sv
hw/rtl/rim_div_cell.sv
hw/rtl/running_image_mean.sv
hw/rtl/rim_checker.sv
tb/testbench.sv
